>>> rtl/core/box_blur_line_filter_unit_macros.svh
// assertion macros for the box blur line filter
`ifndef BOX_BLUR_LINE_FILTER_UNIT_MACROS_SVH
`define BOX_BLUR_LINE_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define BBF_CHECK_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BBF_CHECK_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/bbf_pkg.sv
// shared types, constants and helper functions of the box blur line filter
package bbf_pkg;

  localparam int MAX_BOX_WIDTH = 64;
  localparam int MAX_CHANNELS  = 4;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 4;
  localparam int SUM_W      = 14;
  localparam int CNT_W      = 7;
  localparam int CHAN_W     = 3;
  localparam int RING_AW    = $clog2(MAX_BOX_WIDTH);
  localparam int RD_W       = $clog2(3 * MAX_BOX_WIDTH);
  localparam int DLY_W      = $clog2(MAX_BOX_WIDTH / 2 + 1);
  localparam int NUM_W      = SUM_W + 1;
  localparam int DSH_W      = CNT_W + PIX_W - 1;
  localparam int DIV_CELLS  = PIX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ALIGN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [1:0] ALIGN_RIGHT = 2'd1;

  localparam logic [CNT_W-1:0]  RST_BOX_WIDTH = 7'd3;
  localparam logic [CHAN_W-1:0] RST_CHANNELS  = 3'd4;

  typedef enum logic {FE_RUN, FE_FLUSH} fe_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_c0;
    logic [PIX_W-1:0] pixel_c1;
    logic [PIX_W-1:0] pixel_c2;
    logic [PIX_W-1:0] pixel_c3;
    logic             line_end;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_c0;
    logic [PIX_W-1:0] blurred_c1;
    logic [PIX_W-1:0] blurred_c2;
    logic [PIX_W-1:0] blurred_c3;
    logic             run_last;
  } out_word_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic [CNT_W-1:0]             cov;
    logic [CHAN_W-1:0]            nch;
    logic                         last;
  } emit_t;

  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;
    logic [NUM_CH-1:0][PIX_W-1:0] quo;
    logic [NUM_CH-1:0]            sat;
    logic [DSH_W-1:0]             dsh;
    logic [CHAN_W-1:0]            nch;
    logic                         last;
  } div_word_t;

  function automatic logic [CNT_W-1:0] eff_width(input logic [CNT_W-1:0] wv);
    if (wv == '0) begin
      return CNT_W'(1);
    end else if (wv > CNT_W'(MAX_BOX_WIDTH)) begin
      return CNT_W'(MAX_BOX_WIDTH);
    end
    return wv;
  endfunction

  function automatic logic [CHAN_W-1:0] eff_chans(input logic [CHAN_W-1:0] nv);
    if (nv == '0) begin
      return CHAN_W'(1);
    end else if (nv > CHAN_W'(MAX_CHANNELS)) begin
      return CHAN_W'(MAX_CHANNELS);
    end
    return nv;
  endfunction

  // pixels between the newest one and the output position
  function automatic logic [DLY_W-1:0] box_delay(input logic [CNT_W-1:0] wv,
                                                 input logic [1:0] align);
    logic [CNT_W-1:0] half;
    half = wv >> 1;
    if (wv[0]) begin
      return DLY_W'(half);
    end else if (align == ALIGN_RIGHT) begin
      return DLY_W'(half - CNT_W'(1));
    end
    return DLY_W'(half);
  endfunction

endpackage

>>> rtl/core/bbf_front.sv
// config registers, running channel sums, pixel ring and line-end flush sequencer
module bbf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bbf_pkg::in_word_t                 in_data,
  output logic                              em_valid,
  input  logic                              em_ready,
  output bbf_pkg::emit_t                    em_data,
  output logic                              flushing
);
  import bbf_pkg::*;

  logic [CNT_W-1:0]             cfg_width, cfg_width_next;
  logic [1:0]                   cfg_align, cfg_align_next;
  logic [CHAN_W-1:0]            cfg_chans, cfg_chans_next;
  fe_state_t                    state, state_next;
  logic [NUM_CH-1:0][SUM_W-1:0] sums, sums_next, sums_upd;
  logic [CNT_W-1:0]             taken, taken_next, taken_inc;
  logic [RING_AW-1:0]           rp, rp_next, rp_inc, rd_addr;
  logic [DLY_W-1:0]             k, k_next, d;
  logic [CNT_W-1:0]             w, w_next, w_minus_k, cov_run, cov_flush;
  logic [CNT_W:0]               reach;
  logic [RD_W-1:0]              rd_sum, rd_a, rd_b;
  logic [NUM_CH*PIX_W-1:0]      pix, rd_q, byp_data, rd_pix;
  logic                         byp;
  logic                         in_fire, flush_go, sub_en, last_k, clear;
  logic                         emit_valid;
  emit_t                        emit_word;
  logic [NUM_CH*PIX_W-1:0]      ring [MAX_BOX_WIDTH];

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_width_next = cfg_width;
    cfg_align_next = cfg_align;
    cfg_chans_next = cfg_chans;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_WIDTH:     cfg_width_next = cfg_data;
        REG_KERNEL_ALIGN:  cfg_align_next = cfg_data[1:0];
        REG_CHANNEL_COUNT: cfg_chans_next = cfg_data[CHAN_W-1:0];
        default:           cfg_width_next = cfg_width;
      endcase
    end
  end

  assign w      = eff_width(cfg_width);
  assign w_next = eff_width(cfg_width_next);
  assign d      = box_delay(w, cfg_align);
  assign pix    = {in_data.pixel_c3, in_data.pixel_c2, in_data.pixel_c1, in_data.pixel_c0};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FE_RUN: begin
        if (in_fire && in_data.line_end && d != '0) begin
          state_next = FE_FLUSH;
        end
      end
      FE_FLUSH: begin
        if (flush_go && last_k) begin
          state_next = FE_RUN;
        end
      end
      default: state_next = FE_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    flush_go = 1'b0;
    flushing = 1'b0;
    case (state)
      FE_RUN: begin
        in_ready = em_ready && !cfg_valid;
      end
      FE_FLUSH: begin
        flush_go = em_ready;
        flushing = 1'b1;
      end
      default: flushing = 1'b0;
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  assign last_k    = (k == d);
  assign reach     = {1'b0, taken} + (CNT_W+1)'(k) - (CNT_W+1)'(1);
  assign sub_en    = in_fire ? (taken >= w) : (flush_go && reach >= {1'b0, w});
  assign taken_inc = (taken == CNT_W'(MAX_BOX_WIDTH)) ? taken : taken + CNT_W'(1);
  assign rp_inc    = (rp == RING_AW'(MAX_BOX_WIDTH - 1)) ? '0 : rp + RING_AW'(1);
  assign w_minus_k = w - CNT_W'(k);
  assign cov_run   = (taken_inc < w) ? taken_inc : w;
  assign cov_flush = (w_minus_k < taken) ? w_minus_k : taken;
  assign clear     = (in_fire && in_data.line_end && d == '0) || (flush_go && last_k);
  assign rd_pix    = byp ? byp_data : rd_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sums_upd[c] = sums[c]
                    - (sub_en  ? SUM_W'(rd_pix[c*PIX_W +: PIX_W]) : '0)
                    + (in_fire ? SUM_W'(pix[c*PIX_W +: PIX_W])    : '0);
    end
  end

  always_comb begin
    sums_next  = sums;
    taken_next = taken;
    rp_next    = rp;
    k_next     = k;
    if (in_fire) begin
      sums_next  = sums_upd;
      taken_next = taken_inc;
      rp_next    = rp_inc;
      k_next     = DLY_W'(1);
    end else if (flush_go) begin
      sums_next = sums_upd;
      k_next    = k + DLY_W'(1);
    end
    if (clear) begin
      sums_next  = '0;
      taken_next = '0;
      rp_next    = '0;
    end
  end

  // ring slot of the pixel that leaves the window at the next step
  always_comb begin
    rd_sum = RD_W'(rp_next) + RD_W'(MAX_BOX_WIDTH) - RD_W'(w_next)
             + ((state_next == FE_FLUSH) ? RD_W'(k_next) - RD_W'(1) : '0);
    rd_a = (rd_sum >= RD_W'(MAX_BOX_WIDTH)) ? rd_sum - RD_W'(MAX_BOX_WIDTH) : rd_sum;
    rd_b = (rd_a >= RD_W'(MAX_BOX_WIDTH)) ? rd_a - RD_W'(MAX_BOX_WIDTH) : rd_a;
    rd_addr = rd_b[RING_AW-1:0];
  end

  always_comb begin
    emit_valid     = 1'b0;
    emit_word.sums = sums_upd;
    emit_word.nch  = eff_chans(cfg_chans);
    emit_word.cov  = cov_run;
    emit_word.last = 1'b1;
    if (in_fire) begin
      emit_valid     = taken_inc > CNT_W'(d);
      emit_word.last = !(in_data.line_end && d != '0);
    end else if (flush_go) begin
      emit_valid     = reach >= (CNT_W+1)'(d);
      emit_word.cov  = cov_flush;
      emit_word.last = last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[rp] <= pix;
    end
    rd_q     <= ring[rd_addr];
    byp_data <= pix;
  end

  always_ff @(posedge clk) begin
    if (em_ready) begin
      em_data <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= RST_BOX_WIDTH;
      cfg_align <= '0;
      cfg_chans <= RST_CHANNELS;
      state     <= FE_RUN;
      sums      <= '0;
      taken     <= '0;
      rp        <= '0;
      k         <= '0;
      byp       <= 1'b0;
      em_valid  <= 1'b0;
    end else begin
      cfg_width <= cfg_width_next;
      cfg_align <= cfg_align_next;
      cfg_chans <= cfg_chans_next;
      state     <= state_next;
      sums      <= sums_next;
      taken     <= taken_next;
      rp        <= rp_next;
      k         <= k_next;
      byp       <= in_fire && (rd_addr == rp);
      if (em_ready) begin
        em_valid <= emit_valid;
      end
    end
  end

endmodule

>>> rtl/core/bbf_div_cell.sv
// one restoring divider cell: one quotient bit for every channel, registered
module bbf_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  bbf_pkg::div_word_t  up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output bbf_pkg::div_word_t  dn_data
);
  import bbf_pkg::*;

  div_word_t step;

  always_comb begin
    step     = up_data;
    step.dsh = up_data.dsh >> 1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (up_data.rem[c] >= NUM_W'(up_data.dsh)) begin
        step.rem[c] = up_data.rem[c] - NUM_W'(up_data.dsh);
        step.quo[c] = {up_data.quo[c][PIX_W-2:0], 1'b1};
      end else begin
        step.quo[c] = {up_data.quo[c][PIX_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= step;
    end
  end

endmodule

>>> rtl/core/box_blur_line_filter_unit.sv
// box blur line filter top level: running-sum front end, rounding stage, divider cell chain
// throughput: one pixel word per cycle unless back-pressured or a config write is offered;
//   a line-end word with a nonzero window delay then holds the input while the front end
//   flushes one position per cycle over that delay, unless back-pressured
// reset: synchronous; clears sums, counters and pipeline valids, config to width 3,
//   centred, 4 channels; the pixel ring memory is not cleared
`include "box_blur_line_filter_unit_macros.svh"

module box_blur_line_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bbf_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bbf_pkg::out_word_t                result
);
  import bbf_pkg::*;

  logic                         em_valid, em_ready, fe_flushing;
  emit_t                        em_data;
  logic                         prep_v;
  div_word_t                    prep_data, prep_next;
  logic [DIV_CELLS:0]           ch_valid, ch_ready;
  div_word_t                    ch_data [DIV_CELLS+1];
  div_word_t                    fin;
  logic [NUM_CH-1:0][PIX_W-1:0] res;

  bbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .em_valid  (em_valid),
    .em_ready  (em_ready),
    .em_data   (em_data),
    .flushing  (fe_flushing)
  );

  // rounding offset, saturation test and divisor alignment
  always_comb begin
    prep_next.quo  = '0;
    prep_next.dsh  = {em_data.cov, {(PIX_W-1){1'b0}}};
    prep_next.nch  = em_data.nch;
    prep_next.last = em_data.last;
    for (int c = 0; c < NUM_CH; c++) begin
      prep_next.rem[c] = {1'b0, em_data.sums[c]} + NUM_W'(em_data.cov >> 1);
      prep_next.sat[c] = prep_next.rem[c] >= {em_data.cov, {PIX_W{1'b0}}};
    end
  end

  assign em_ready = !prep_v || ch_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_v <= 1'b0;
    end else if (em_ready) begin
      prep_v <= em_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready) begin
      prep_data <= prep_next;
    end
  end

  assign ch_valid[0] = prep_v;
  assign ch_data[0]  = prep_data;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : gen_cells
    bbf_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_data  (ch_data[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_data  (ch_data[i+1])
    );
  end

  assign ch_ready[DIV_CELLS] = out_ready;
  assign out_valid           = ch_valid[DIV_CELLS];
  assign fin                 = ch_data[DIV_CELLS];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (CHAN_W'(c) >= fin.nch) begin
        res[c] = '0;
      end else if (fin.sat[c]) begin
        res[c] = '1;
      end else begin
        res[c] = fin.quo[c];
      end
    end
    result.blurred_c0 = res[0];
    result.blurred_c1 = res[1];
    result.blurred_c2 = res[2];
    result.blurred_c3 = res[3];
    result.run_last   = fin.last;
  end

  `BBF_CHECK_NOW(a_cfg_excl, cfg_valid && cfg_ready, !(in_valid && in_ready), "cfg and pixel")
  `BBF_CHECK_NOW(a_flush_block, fe_flushing, !in_ready, "pixel word taken during flush")
  `BBF_CHECK_NEXT(a_prep_hold, prep_v && !ch_ready[0], prep_v && $stable(prep_data), "prep lost")

endmodule
